// File: hdl/incremental_pid_with_antiwindup_top_defines.svh
// assertion macros for the incremental pid controller
`ifndef INCREMENTAL_PID_WITH_ANTIWINDUP_TOP_DEFINES_SVH
`define INCREMENTAL_PID_WITH_ANTIWINDUP_TOP_DEFINES_SVH

// check that holds while out of reset
`define IPID_CHECK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also covers the reset cycles
`define IPID_CHECK_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/ipid_pkg.sv
// shared types, constants and helpers for the incremental pid controller
package ipid_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = 64;
    localparam int DIV_D_W = 34;
    localparam int ACC_W   = 40;
    localparam int QUO_W   = 39;

    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [2:0] REG_SAMPLE_TIME  = 3'd2;
    localparam logic [2:0] REG_RESET_TIME   = 3'd3;
    localparam logic [2:0] REG_WINDUP_LIMIT = 3'd4;

    localparam logic [MUL_B_W-1:0] PID_DIV_SCALE = 17'd100000;
    localparam logic [DIV_D_W-1:0] P_DIV         = 34'd1000;
    localparam logic [DIV_D_W-1:0] FIXED_DIV     = 34'd10;

    localparam logic signed [ACC_W:0] ACC_MAX = 41'sh07F_FFFF_FFFF;
    localparam logic signed [ACC_W:0] ACC_MIN = -41'sh080_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D2,
        ST_TA,
        ST_TE,
        ST_KI,
        ST_DV,
        ST_DQ,
        ST_KM,
        ST_MQ,
        ST_OUT
    } state_t;

    function automatic logic signed [MUL_A_W-1:0] times100(input logic signed [MUL_A_W-1:0] x);
        return (x <<< 6) + (x <<< 5) + (x <<< 2);
    endfunction

endpackage

// File: hdl/ipid_mul.sv
// bit-serial shift-add multiplier, signed by unsigned
module ipid_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [ipid_pkg::MUL_A_W-1:0]   a,
    input  logic        [ipid_pkg::MUL_B_W-1:0]   b,
    output logic                                  done,
    output logic signed [ipid_pkg::MUL_P_W-1:0]   p
);
    import ipid_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic signed [MUL_P_W-1:0] a_reg;
    logic        [MUL_B_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= MUL_P_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

// File: hdl/ipid_div.sv
// bit-serial restoring divider: trunc(n * 2^frac / d), saturated to 40 bits
module ipid_div #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [ipid_pkg::MUL_P_W-1:0]   n,
    input  logic        [ipid_pkg::DIV_D_W-1:0]   d,
    output logic                                  done,
    output logic signed [ipid_pkg::ACC_W-1:0]     q
);
    import ipid_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam int CMP_W = MUL_P_W + QUO_W;
    localparam int PRE   = QUO_W - FRAC_BITS;

    logic        [MUL_P_W-1:0] un;
    logic                      ovf;
    logic        [DIV_D_W-1:0] rem_reg;
    logic        [QUO_W-1:0]   sh_reg;
    logic        [QUO_W-1:0]   q_reg;
    logic        [DIV_D_W-1:0] d_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      neg_reg;
    logic                      ovf_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic        [DIV_D_W:0]   trial;
    logic                      ge;
    logic signed [ACC_W-1:0]   mag;

    assign un  = n[MUL_P_W-1] ? MUL_P_W'(-n) : MUL_P_W'(n);
    assign ovf = CMP_W'(un) >= (CMP_W'(d) << PRE);

    assign trial = {rem_reg, sh_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !ovf;
                done_reg <= ovf;
                cnt_reg  <= CNT_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_D_W'(un >> PRE);
            sh_reg  <= QUO_W'(un << FRAC_BITS);
            q_reg   <= '0;
            d_reg   <= d;
            neg_reg <= n[MUL_P_W-1];
            ovf_reg <= ovf;
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_D_W'(trial - {1'b0, d_reg}) : trial[DIV_D_W-1:0];
            sh_reg  <= sh_reg << 1;
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign mag  = {1'b0, q_reg};
    assign done = done_reg;

    always_comb begin
        if (ovf_reg) begin
            q = neg_reg ? ACC_W'(ACC_MIN) : ACC_W'(ACC_MAX);
        end else begin
            q = neg_reg ? -mag : mag;
        end
    end
endmodule

// File: hdl/incremental_pid_with_antiwindup_top.sv
// incremental pid controller with anti-windup, sequenced over serial units
// sequence: a start step, six passes of the bit-serial multiplier and two passes
// of the bit-serial divider, plus handover steps; one request at a time
// throughput: a new request is taken only after the last result has entered
// the result register, since the serial units are shared
// reset: synchronous active-low aresetn loads register defaults, clears the
// error history and drive accumulator, and empties the result register
module incremental_pid_with_antiwindup_top #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [11:0]  s_error_tenths,
    input  logic                s_clear,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_drive_tenths,
    output logic signed [23:0]  m_limited_drive,
    output logic                m_windup_hit
);
    import ipid_pkg::*;

    `include "incremental_pid_with_antiwindup_top_defines.svh"

    // configuration registers
    logic [13:0] kp_reg, kd_reg, wl_reg;
    logic [15:0] ts_reg, tn_reg;

    // controller state
    logic signed [11:0]      e_reg, last_reg, prev_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // sequencer
    state_t state_reg, state_next;
    logic   issued_reg;

    // intermediate products
    logic signed [MUL_A_W-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [MUL_P_W-1:0] num_reg;
    logic        [DIV_D_W-1:0] dvs_reg;
    logic signed [ACC_W-1:0]   delta_reg, m_reg;

    // result register
    logic                m_valid_reg;
    logic [9:0]          drive_reg;
    logic signed [23:0]  limited_reg;
    logic                hit_reg;

    // serial unit hookup
    logic                      mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic signed [MUL_P_W-1:0] div_n;
    logic        [DIV_D_W-1:0] div_d;
    logic signed [ACC_W-1:0]   div_q;

    logic pid_mode;
    logic out_free;
    logic out_load;
    logic accept;

    // error terms, sign extended
    logic signed [MUL_A_W-1:0] e_w, e1_w, e2_w, de_w, d2_w, inner_w;

    assign pid_mode = (tn_reg != 16'd0) && (ts_reg < tn_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    assign e_w     = MUL_A_W'(e_reg);
    assign e1_w    = MUL_A_W'(last_reg);
    assign e2_w    = MUL_A_W'(prev_reg);
    assign de_w    = e_w - e1_w;
    assign d2_w    = e_w - (e1_w <<< 1) + e2_w;
    assign inner_w = p2_reg + times100(p3_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= 14'd100;
            kd_reg <= 14'd0;
            ts_reg <= 16'd10;
            tn_reg <= 16'd0;
            wl_reg <= 14'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:    kp_reg <= cfg_wdata[13:0];
                REG_DERIV_GAIN:   kd_reg <= cfg_wdata[13:0];
                REG_SAMPLE_TIME:  ts_reg <= cfg_wdata;
                REG_RESET_TIME:   tn_reg <= cfg_wdata;
                REG_WINDUP_LIMIT: wl_reg <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_D2;
            ST_D2:   if (mul_done) state_next = ST_TA;
            ST_TA:   if (mul_done) state_next = ST_TE;
            ST_TE:   if (mul_done) state_next = ST_KI;
            ST_KI:   if (mul_done) state_next = ST_DV;
            ST_DV:   if (mul_done) state_next = ST_DQ;
            ST_DQ:   if (div_done) state_next = ST_KM;
            ST_KM:   if (mul_done) state_next = ST_MQ;
            ST_MQ:   if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, unit starts and operand selection
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_n     = num_reg;
        div_d     = dvs_reg;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_D2: begin
                // derivative difference times kd
                mul_start = !issued_reg;
                mul_a     = d2_w;
                mul_b     = MUL_B_W'(kd_reg);
            end
            ST_TA: begin
                mul_start = !issued_reg;
                mul_a     = times100(de_w) + p1_reg;
                mul_b     = MUL_B_W'(tn_reg);
            end
            ST_TE: begin
                // integral share
                mul_start = !issued_reg;
                mul_a     = e1_w;
                mul_b     = MUL_B_W'(ts_reg);
            end
            ST_KI: begin
                mul_start = !issued_reg;
                mul_a     = pid_mode ? inner_w : de_w;
                mul_b     = MUL_B_W'(kp_reg);
            end
            ST_DV: begin
                // divisor for pid mode
                mul_start = !issued_reg;
                mul_a     = MUL_A_W'(tn_reg);
                mul_b     = PID_DIV_SCALE;
            end
            ST_DQ: div_start = !issued_reg;
            ST_KM: begin
                // sliding window numerator
                mul_start = !issued_reg;
                mul_a     = e_w[MUL_A_W-1] ? -e_w : e_w;
                mul_b     = MUL_B_W'(kp_reg);
            end
            ST_MQ: begin
                div_start = !issued_reg;
                div_d     = (wl_reg == 14'd0) ? P_DIV : FIXED_DIV;
            end
            ST_OUT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end else if (mul_done || div_done) begin
                issued_reg <= 1'b0;
            end
        end
    end

    // capture unit results
    always_ff @(posedge aclk) begin
        if (mul_done) begin
            case (state_reg)
                ST_D2: p1_reg  <= MUL_A_W'(mul_p);
                ST_TA: p2_reg  <= MUL_A_W'(mul_p);
                ST_TE: p3_reg  <= MUL_A_W'(mul_p);
                ST_KI: num_reg <= mul_p;
                ST_DV: dvs_reg <= pid_mode ? DIV_D_W'(mul_p) : P_DIV;
                ST_KM: num_reg <= (wl_reg == 14'd0) ? mul_p : MUL_P_W'(wl_reg);
                default: ;
            endcase
        end
        if (div_done) begin
            case (state_reg)
                ST_DQ: delta_reg <= div_q;
                ST_MQ: m_reg     <= div_q;
                default: ;
            endcase
        end
    end

    // drive update, anti-windup clamp and output scaling
    logic signed [ACC_W:0]   sum_w;
    logic signed [ACC_W-1:0] y0, y1;
    logic signed [ACC_W+1:0] upper_w, y0_x, neg_m;
    logic signed [ACC_W+3:0] t10;
    logic        [ACC_W+3:0] mag_t;
    logic signed [ACC_W+4:0] t_w;
    logic                    t_neg;
    logic [9:0]              drive_w;
    logic signed [23:0]      lim_w;

    always_comb begin
        sum_w = ACC_W'(0) + (41'(acc_reg) + 41'(delta_reg));
        if (sum_w > ACC_MAX) begin
            y0 = ACC_W'(ACC_MAX);
        end else if (sum_w < ACC_MIN) begin
            y0 = ACC_W'(ACC_MIN);
        end else begin
            y0 = sum_w[ACC_W-1:0];
        end
        upper_w = 42'(m_reg) + (42'sd100 <<< FRAC_BITS);
        neg_m   = -42'(m_reg);
        y0_x    = 42'(y0);
        y1      = y0;
        if (y0 > 0 && y0_x > upper_w) begin
            y1 = upper_w[ACC_W-1:0];
        end
        if (y0 < 0 && y0_x < neg_m) begin
            y1 = neg_m[ACC_W-1:0];
        end
        // times ten, truncated toward zero
        t10   = (44'(y1) <<< 3) + (44'(y1) <<< 1);
        t_neg = t10[ACC_W+3];
        mag_t = (t_neg ? 44'(-t10) : 44'(t10)) >> FRAC_BITS;
        t_w   = t_neg ? -45'(mag_t) : 45'(mag_t);
        if (t_w > 45'sd1000) begin
            drive_w = 10'd1000;
        end else if (t_w < 0) begin
            drive_w = 10'd0;
        end else begin
            drive_w = t_w[9:0];
        end
        if (t_w > 45'sd8388607) begin
            lim_w = 24'sh7FFFFF;
        end else if (t_w < -45'sd8388608) begin
            lim_w = -24'sh800000;
        end else begin
            lim_w = t_w[23:0];
        end
    end

    // history and drive, clear applied at request time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            prev_reg <= '0;
            acc_reg  <= '0;
        end else if (accept) begin
            if (s_clear) begin
                last_reg <= '0;
                prev_reg <= '0;
                acc_reg  <= '0;
            end
        end else if (out_load) begin
            acc_reg  <= y1;
            prev_reg <= last_reg;
            last_reg <= e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            e_reg <= s_error_tenths;
        end
    end

    // result register, free again once the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_reg   <= drive_w;
            limited_reg <= lim_w;
            hit_reg     <= (y1 != y0);
        end
    end

    ipid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    ipid_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .n       (div_n),
        .d       (div_d),
        .done    (div_done),
        .q       (div_q)
    );

    assign m_valid         = m_valid_reg;
    assign m_drive_tenths  = drive_reg;
    assign m_limited_drive = limited_reg;
    assign m_windup_hit    = hit_reg;

    // a taken request keeps the block busy
    `IPID_CHECK(a_busy_after_req, (s_valid && s_ready) |=> !s_ready, "request taken while busy")
    // a new result only comes from the output step
    `IPID_CHECK(a_result_src, $rose(m_valid) |-> $past(state_reg == ST_OUT), "stray result")
    // drive stays within range
    `IPID_CHECK(a_drive_range, m_valid |-> (m_drive_tenths <= 10'd1000), "drive out of range")
    // reset empties the result register
    `IPID_CHECK_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")
endmodule

// File: tb/incremental_pid_with_antiwindup_top_tb.sv
// testbench for the incremental pid controller with anti-windup
module incremental_pid_with_antiwindup_top_tb;
    import ipid_pkg::*;

    localparam int         FRAC       = FRAC_BITS_DEF;
    localparam logic [2:0] REG_UNUSED = 3'd5;    // no register lives here
    localparam longint     DRV_MAX    = 64'sh7F_FFFF_FFFF;
    localparam longint     DRV_MIN    = -64'sh80_0000_0000;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         DRAIN_WAIT = 250;     // a little above the block's latency

    typedef struct {
        logic [9:0]         drive_tenths;
        logic signed [23:0] limited_drive;
        logic               windup_hit;
    } drive_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = REG_PROP_GAIN;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [11:0] s_error_tenths = '0;
    logic               s_clear = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [9:0]         m_drive_tenths;
    logic signed [23:0] m_limited_drive;
    logic               m_windup_hit;

    incremental_pid_with_antiwindup_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_error_tenths(s_error_tenths), .s_clear(s_clear),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_drive_tenths(m_drive_tenths), .m_limited_drive(m_limited_drive),
        .m_windup_hit(m_windup_hit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // controller image kept alongside the block
    int unsigned kp_q, kd_q, ts_q, tn_q, wup_q;
    longint      err_last, err_prev, drive_acc;

    drive_res_t drive_queue[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;

    // trunc(n * 2^FRAC / d) toward zero, saturated to the accumulator range
    function automatic longint fixed_quot(input longint n, input longint d);
        longint un, q, rm, mag;
        logic   neg;
        neg = n < 0;
        un  = neg ? -n : n;
        q   = un / d;
        rm  = un % d;
        if (q >= (64'sd1 <<< (39 - FRAC)))
            return neg ? DRV_MIN : DRV_MAX;
        mag = (q <<< FRAC) + ((rm <<< FRAC) / d);
        return neg ? -mag : mag;
    endfunction

    // one controller step: new drive from this error and the history
    function automatic drive_res_t next_drive(input logic signed [11:0] err, input logic clr);
        longint     e, e1, e2, inner, delta, y, y_pre, m, upper, t, mag;
        drive_res_t r;
        e = longint'(err);
        if (clr) begin
            err_last  = 0;
            err_prev  = 0;
            drive_acc = 0;
        end
        e1 = err_last;
        e2 = err_prev;
        if (tn_q > 0 && ts_q < tn_q) begin
            // pi(d) form
            inner = (e - e1) * tn_q * 100 + longint'(ts_q) * e1 * 100
                  + longint'(kd_q) * (e - 2 * e1 + e2) * tn_q;
            delta = fixed_quot(longint'(kp_q) * inner, 64'sd100000 * tn_q);
        end else begin
            delta = fixed_quot(longint'(kp_q) * (e - e1), 1000);
        end
        y = drive_acc + delta;
        if (y > DRV_MAX) y = DRV_MAX;
        if (y < DRV_MIN) y = DRV_MIN;
        y_pre = y;
        if (wup_q == 0)
            m = fixed_quot(longint'(kp_q) * (e < 0 ? -e : e), 1000);
        else
            m = fixed_quot(longint'(wup_q), 10);
        upper = m + (64'sd100 <<< FRAC);
        if (y > 0 && y > upper) y = upper;
        if (y < 0 && y < -m) y = -m;
        r.windup_hit = (y != y_pre);
        drive_acc = y;
        err_prev  = e1;
        err_last  = e;
        t   = y * 10;
        mag = (t < 0 ? -t : t) >>> FRAC;
        t   = t < 0 ? -mag : mag;
        r.drive_tenths  = t > 1000 ? 10'd1000 : (t < 0 ? 10'd0 : t[9:0]);
        if (t > 64'sh7F_FFFF) t = 64'sh7F_FFFF;
        if (t < -64'sh80_0000) t = -64'sh80_0000;
        r.limited_drive = t[23:0];
        return r;
    endfunction

    // request side: predict on acceptance; result side: compare with oldest
    always @(posedge aclk) begin
        drive_res_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_valid && s_ready)
                drive_queue.push_back(next_drive(s_error_tenths, s_clear));
            if (m_valid && m_ready) begin
                if (drive_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: drive %0d limited %0d hit %0b",
                                 m_drive_tenths, m_limited_drive, m_windup_hit);
                end else begin
                    want = drive_queue.pop_front();
                    if (m_drive_tenths !== want.drive_tenths
                        || m_limited_drive !== want.limited_drive
                        || m_windup_hit !== want.windup_hit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: drive %0d/%0d limited %0d/%0d hit %0b/%0b",
                                     m_drive_tenths, want.drive_tenths, m_limited_drive,
                                     want.limited_drive, m_windup_hit, want.windup_hit);
                    end
                end
            end
        end
    end

    // watchdog: nothing moving for too long means the block is hung
    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("incremental_pid_with_antiwindup_top verification failed");
            $finish;
        end
    end

    // receiver stalls in modes of random length: open, coin flip, mostly shut
    int rx_left = 0;
    int rx_mode = 0;
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    // send one request, in bursts with random gaps between them
    task automatic send_request(input logic signed [11:0] err, input logic clr);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_error_tenths <= err;
        s_clear        <= clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // lower valid and wait until every expected result is back and the block is quiet
    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (drive_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // register write, mirrored in the controller image with the upper bits of gains and limit dropped
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN:    kp_q  = val[13:0];
            REG_DERIV_GAIN:   kd_q  = val[13:0];
            REG_SAMPLE_TIME:  ts_q  = val;
            REG_RESET_TIME:   tn_q  = val;
            REG_WINDUP_LIMIT: wup_q = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic [15:0] kp, input logic [15:0] kd, input logic [15:0] ts,
                             input logic [15:0] tn, input logic [15:0] wup);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_SAMPLE_TIME, ts);
        write_reg(REG_RESET_TIME, tn);
        write_reg(REG_WINDUP_LIMIT, wup);
    endtask

    // reset defaults: p-only, sliding limit, error extremes and clear
    task automatic test_defaults;
        send_request(12'sd2000, 1'b0);
        send_request(-12'sd2000, 1'b0);
        send_request(12'sd0, 1'b0);
        send_request(12'sd2047, 1'b0);
        send_request(-12'sd2048, 1'b0);
        send_request(12'sd500, 1'b1);
        drain();
    endtask

    // pid mode with derivative, then fixed margin and equal times
    task automatic test_modes;
        set_gains(16'd250, 16'd300, 16'd10, 16'd100, 16'd0);
        send_request(12'sd100, 1'b1);
        send_request(12'sd300, 1'b0);
        send_request(-12'sd150, 1'b0);
        send_request(12'sd800, 1'b0);
        drain();
        // zero sample time gives no integral; equal times fall back to p-only
        write_reg(REG_SAMPLE_TIME, 16'd0);
        write_reg(REG_WINDUP_LIMIT, 16'd10000);
        send_request(12'sd400, 1'b0);
        send_request(-12'sd400, 1'b0);
        drain();
        write_reg(REG_SAMPLE_TIME, 16'd100);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_request(12'sd1000, 1'b0);
        send_request(12'sd1000, 1'b0);
        drain();
    endtask

    // largest gains with alternating full-scale errors push the sum into saturation
    task automatic test_saturation;
        set_gains(16'hFFFF, 16'hFFFF, 16'd65534, 16'hFFFF, 16'hFFFF);
        send_request(12'sd2047, 1'b1);
        send_request(-12'sd2048, 1'b0);
        send_request(12'sd2047, 1'b0);
        send_request(-12'sd2048, 1'b0);
        drain();
        write_reg(REG_WINDUP_LIMIT, 16'd0);
        send_request(12'sd2047, 1'b0);
        send_request(-12'sd2048, 1'b0);
        send_request(-12'sd1, 1'b0);
        drain();
    endtask

    // random errors under one setting; mostly in range, some full 12-bit values
    task automatic test_random(input int count);
        logic signed [11:0] err;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                err = 12'($urandom);
            else if ($urandom_range(0, 3) == 0)
                err = 12'(int'($urandom_range(0, 100)) - 50);
            else
                err = 12'(int'($urandom_range(0, 4000)) - 2000);
            send_request(err, $urandom_range(0, 19) == 0);
        end
        drain();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        kp_q = 100; kd_q = 0; ts_q = 10; tn_q = 0; wup_q = 0;
        err_last = 0; err_prev = 0; drive_acc = 0;
        test_defaults();
        test_modes();
        test_saturation();
        // small gains with pi, sliding limit
        set_gains(16'd50, 16'd0, 16'd5, 16'd600, 16'd0);
        test_random(225);
        // full pid, fixed margin
        set_gains(16'd400, 16'd1500, 16'd20, 16'd300, 16'd600);
        test_random(225);
        // p-only, zero gain
        set_gains(16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
        test_random(225);
        // random setting across the whole register range
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        test_random(225);
        // extreme gains, short reset time
        set_gains(16'd10000, 16'd10000, 16'd0, 16'd1, 16'd1);
        test_random(225);
        if (mismatches == 0) begin
            $display("incremental_pid_with_antiwindup_top verification clean");
        end else begin
            $display("incremental_pid_with_antiwindup_top verification failed");
        end
        $finish;
    end

endmodule
